FILE: hdl/llpt_pkg.sv
// ----------------------------------------------------------------------------
// llpt_pkg
// shared types and constants for the least loaded peer table
// ----------------------------------------------------------------------------
package llpt_pkg;

	parameter int TABLE_ENTRIES = 16;

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	localparam logic [CNT_W-1:0] TABLE_FULL = CNT_W'(TABLE_ENTRIES);
	localparam logic [6:0]       LOAD_LIMIT = 7'd101;

	typedef enum logic [0:0] {
		REQ_REPORT = 1'b0,
		REQ_PICK   = 1'b1
	} req_kind_t;

	typedef enum logic [2:0] {
		ST_UPDATED  = 3'd0,
		ST_INSERTED = 3'd1,
		ST_DROPPED  = 3'd2,
		ST_NONE     = 3'd3,
		ST_FOUND    = 3'd4
	} status_t;

	typedef struct packed {
		req_kind_t   req_type;
		logic [31:0] peer_ip;
		logic [15:0] peer_port;
		logic [6:0]  peer_load;
	} req_word_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] target_addr;
		logic [15:0] chosen_port;
		logic [6:0]  target_load;
	} rsp_word_t;

	typedef struct packed {
		logic [31:0] addr;
		logic [15:0] port;
		logic [6:0]  load;
	} entry_t;

endpackage

FILE: hdl/least_loaded_peer_table_core.sv
// ----------------------------------------------------------------------------
// least_loaded_peer_table_core
// peer table with load reports and least loaded pick, walked one entry a cycle
// ----------------------------------------------------------------------------
// channel | handshake           | word       | carries
// req     | req_valid/req_stall | req        | load report or pick request
// rsp     | rsp_valid/rsp_stall | rsp        | status and chosen peer
//
// an item runs through scan, resolve and finish before the next acceptance; the
// scan walks the stored entries and is skipped with an empty table; the walk reads
// one entry a cycle through the single read port of the table ram
// req_stall is high from acceptance until the result is in the output register
// a stalled result does not block the next acceptance, but that next item
// waits in its last state until the output register drains; reset clears the count
// ----------------------------------------------------------------------------
module least_loaded_peer_table_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  llpt_pkg::req_word_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output llpt_pkg::rsp_word_t rsp
);

	typedef enum logic [1:0] {
		IDLE,
		SCAN,
		RESOLVE,
		FINISH
	} state_t;

	state_t                        state_q;
	llpt_pkg::req_word_t           req_q;
	logic [llpt_pkg::CNT_W-1:0]    count_q;
	logic [llpt_pkg::IDX_W-1:0]    last_q;
	logic [llpt_pkg::IDX_W-1:0]    iss_idx_q;
	logic                          iss_on_q;
	logic                          chk_vld_s1;
	logic [llpt_pkg::IDX_W-1:0]    chk_idx_s1;
	logic                          found_q;
	logic [llpt_pkg::IDX_W-1:0]    hit_idx_q;
	logic [6:0]                    best_load_q;
	llpt_pkg::entry_t              best_q;
	llpt_pkg::rsp_word_t           res_q;
	logic                          out_valid_q;
	llpt_pkg::rsp_word_t           out_q;

	logic                          accept;
	logic                          rd_en;
	llpt_pkg::entry_t              rd_entry;
	logic                          wr_en;
	logic [llpt_pkg::IDX_W-1:0]    wr_addr;
	llpt_pkg::entry_t              wr_entry;
	logic                          is_match;
	logic                          has_room;
	logic                          out_load;
	llpt_pkg::rsp_word_t           res_d;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != IDLE);
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	assign rd_en    = (state_q == SCAN) && iss_on_q;
	assign is_match = (rd_entry.addr == req_q.peer_ip) && (rd_entry.port == req_q.peer_port);
	assign has_room = (count_q < llpt_pkg::TABLE_FULL);
	assign out_load = (state_q == FINISH) && (!out_valid_q || !rsp_stall);

	assign wr_entry = '{addr: req_q.peer_ip, port: req_q.peer_port, load: req_q.peer_load};
	assign wr_en    = (state_q == RESOLVE) && (req_q.req_type == llpt_pkg::REQ_REPORT)
			&& (found_q || has_room);
	assign wr_addr  = found_q ? hit_idx_q : count_q[llpt_pkg::IDX_W-1:0];

	always_comb begin
		res_d = '0;
		if (req_q.req_type == llpt_pkg::REQ_REPORT) begin
			if (found_q) begin
				res_d.status = llpt_pkg::ST_UPDATED;
			end else if (has_room) begin
				res_d.status = llpt_pkg::ST_INSERTED;
			end else begin
				res_d.status = llpt_pkg::ST_DROPPED;
			end
		end else if (found_q) begin
			res_d.status      = llpt_pkg::ST_FOUND;
			res_d.target_addr = best_q.addr;
			res_d.chosen_port = best_q.port;
			res_d.target_load = best_q.load;
		end else begin
			res_d.status = llpt_pkg::ST_NONE;
		end
	end

	llpt_ram #(
		.WIDTH($bits(llpt_pkg::entry_t)),
		.DEPTH(llpt_pkg::TABLE_ENTRIES)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_entry),
		.rd_en   (rd_en),
		.rd_addr (iss_idx_q),
		.rd_data (rd_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			req_q       <= '0;
			count_q     <= '0;
			last_q      <= '0;
			iss_idx_q   <= '0;
			iss_on_q    <= 1'b0;
			chk_vld_s1  <= 1'b0;
			chk_idx_s1  <= '0;
			found_q     <= 1'b0;
			hit_idx_q   <= '0;
			best_load_q <= llpt_pkg::LOAD_LIMIT;
			best_q      <= '0;
			res_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_load) begin
				out_q       <= res_q;
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			chk_vld_s1 <= rd_en;
			chk_idx_s1 <= iss_idx_q;

			case (state_q)
				IDLE: begin
					if (accept) begin
						req_q       <= req;
						found_q     <= 1'b0;
						best_load_q <= llpt_pkg::LOAD_LIMIT;
						iss_idx_q   <= '0;
						last_q      <= llpt_pkg::IDX_W'(count_q - 1'b1);
						if (count_q == '0) begin
							state_q <= RESOLVE;
						end else begin
							iss_on_q <= 1'b1;
							state_q  <= SCAN;
						end
					end
				end
				SCAN: begin
					if (iss_on_q) begin
						if (iss_idx_q == last_q) begin
							iss_on_q <= 1'b0;
						end else begin
							iss_idx_q <= iss_idx_q + 1'b1;
						end
					end
					if (chk_vld_s1) begin
						if (req_q.req_type == llpt_pkg::REQ_REPORT) begin
							if (is_match && !found_q) begin
								found_q   <= 1'b1;
								hit_idx_q <= chk_idx_s1;
							end
						end else if (rd_entry.load < best_load_q) begin
							found_q     <= 1'b1;
							best_load_q <= rd_entry.load;
							best_q      <= rd_entry;
						end
						if (chk_idx_s1 == last_q) begin
							state_q <= RESOLVE;
						end
					end
				end
				RESOLVE: begin
					res_q <= res_d;
					if ((req_q.req_type == llpt_pkg::REQ_REPORT) && !found_q && has_room) begin
						count_q <= count_q + 1'b1;
					end
					state_q <= FINISH;
				end
				FINISH: begin
					if (out_load) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= llpt_pkg::TABLE_FULL)
		else $error("entry count above table size");

	a_port_conflict: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("table read and write in the same cycle");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> req_stall)
		else $error("request taken while previous one still in work");

	a_found_eligible: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == llpt_pkg::ST_FOUND) |-> rsp.target_load < llpt_pkg::LOAD_LIMIT)
		else $error("overloaded peer chosen");

	a_drop_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == llpt_pkg::ST_DROPPED) |-> count_q == llpt_pkg::TABLE_FULL)
		else $error("report dropped with room left");

	a_zero_targets: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != llpt_pkg::ST_FOUND)
		|-> (rsp.target_addr == '0) && (rsp.chosen_port == '0) && (rsp.target_load == '0))
		else $error("target fields set without a found peer");
`endif

endmodule

FILE: hdl/llpt_ram.sv
// ----------------------------------------------------------------------------
// llpt_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module llpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                             clk,
	input  logic                                             wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]     wr_addr,
	input  logic [WIDTH-1:0]                                 wr_data,
	input  logic                                             rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]     rd_addr,
	output logic [WIDTH-1:0]                                 rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: test/llpt_monitor.sv
// ----------------------------------------------------------------------------
// llpt_monitor
// watches both channels of the peer table, keeps its own copy of the table,
// works out the expected response for every accepted request and compares
// each accepted response field by field with the oldest one still due
// ----------------------------------------------------------------------------
module llpt_monitor (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_stall,
	input  llpt_pkg::req_word_t req,
	input  logic                rsp_valid,
	input  logic                rsp_stall,
	input  llpt_pkg::rsp_word_t rsp,
	output int                  fails,
	output int                  pending
);

	llpt_pkg::entry_t    peers[llpt_pkg::TABLE_ENTRIES];
	int                  peers_held;
	llpt_pkg::rsp_word_t due_rsp[$];

	function automatic llpt_pkg::rsp_word_t table_apply(llpt_pkg::req_word_t w);
		llpt_pkg::rsp_word_t r;
		int                  best;
		logic [6:0]          best_load;
		logic                hit;
		r = '0;
		if (w.req_type == llpt_pkg::REQ_REPORT) begin
			hit = 1'b0;
			for (int i = 0; i < peers_held; i++) begin
				if (!hit && peers[i].addr == w.peer_ip && peers[i].port == w.peer_port) begin
					peers[i].load = w.peer_load;
					hit = 1'b1;
				end
			end
			if (hit) begin
				r.status = llpt_pkg::ST_UPDATED;
			end else if (peers_held < llpt_pkg::TABLE_ENTRIES) begin
				peers[peers_held] = '{addr: w.peer_ip, port: w.peer_port, load: w.peer_load};
				peers_held++;
				r.status = llpt_pkg::ST_INSERTED;
			end else begin
				r.status = llpt_pkg::ST_DROPPED;
			end
		end else begin
			best = -1;
			best_load = llpt_pkg::LOAD_LIMIT;
			// strict compare keeps the lowest index on a tie
			for (int i = 0; i < peers_held; i++) begin
				if (peers[i].load < best_load) begin
					best_load = peers[i].load;
					best = i;
				end
			end
			if (best >= 0) begin
				r.status = llpt_pkg::ST_FOUND;
				r.target_addr = peers[best].addr;
				r.chosen_port = peers[best].port;
				r.target_load = peers[best].load;
			end else begin
				r.status = llpt_pkg::ST_NONE;
			end
		end
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fails++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		llpt_pkg::rsp_word_t want;
		if (!arst_n) begin
			fails = 0;
			peers_held = 0;
			due_rsp.delete();
		end else begin
			if (req_valid && !req_stall)
				due_rsp.push_back(table_apply(req));
			if (rsp_valid && !rsp_stall) begin
				if (due_rsp.size() == 0) begin
					$error("word with nothing due: status %0h", rsp.status);
					fails++;
				end else begin
					want = due_rsp.pop_front();
					check_field("status", 32'(want.status), 32'(rsp.status));
					check_field("target_addr", want.target_addr, rsp.target_addr);
					check_field("chosen_port", 32'(want.chosen_port), 32'(rsp.chosen_port));
					check_field("target_load", 32'(want.target_load), 32'(rsp.target_load));
				end
			end
		end
		pending = due_rsp.size();
	end

endmodule

FILE: test/tb_least_loaded_peer_table_core.sv
// ----------------------------------------------------------------------------
// tb_least_loaded_peer_table_core
// drives load reports and pick requests into the peer table with random gaps
// and back-pressure, including one long response hold-off, and gives the
// verdict from the failure count of the monitor
// ----------------------------------------------------------------------------
module tb_least_loaded_peer_table_core;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_stall;
	llpt_pkg::req_word_t req = '0;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	llpt_pkg::rsp_word_t rsp;
	int                  fails;
	int                  pending;

	int          gap_max = 5;
	logic [31:0] pool_addr[24];
	logic [15:0] pool_port[24];

	always #1 clk = ~clk;

	least_loaded_peer_table_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	llpt_monitor monitor (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.fails     (fails),
		.pending   (pending)
	);

	function automatic llpt_pkg::req_word_t make_word(llpt_pkg::req_kind_t kind,
		logic [31:0] a, logic [15:0] p, logic [6:0] l);
		llpt_pkg::req_word_t w;
		w.req_type = kind;
		w.peer_ip = a;
		w.peer_port = p;
		w.peer_load = l;
		return w;
	endfunction

	function automatic logic [6:0] draw_load();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return 7'd0;
		else if (sel == 1)
			return 7'd127;
		else if (sel < 4)
			return 7'($urandom_range(98, 104));
		return 7'($urandom_range(0, 127));
	endfunction

	function automatic llpt_pkg::req_word_t random_word();
		int sel;
		int k;
		sel = $urandom_range(0, 99);
		if (sel < 30)
			return make_word(llpt_pkg::REQ_PICK, $urandom, 16'($urandom), 7'($urandom));
		if (sel < 85) begin
			k = $urandom_range(0, 23);
			return make_word(llpt_pkg::REQ_REPORT, pool_addr[k], pool_port[k], draw_load());
		end
		return make_word(llpt_pkg::REQ_REPORT, $urandom, 16'($urandom), draw_load());
	endfunction

	task automatic send_word(llpt_pkg::req_word_t w);
		int gap;
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
	endtask

	initial begin
		for (int i = 0; i < 24; i++) begin
			pool_addr[i] = $urandom;
			pool_port[i] = 16'($urandom);
		end
		// same address on another port, same port on another address
		pool_addr[5] = pool_addr[4];
		pool_port[7] = pool_port[6];
		pool_addr[9] = pool_addr[8];

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, then overloaded-only table
		send_word(make_word(llpt_pkg::REQ_PICK, '1, '1, '1));
		send_word(make_word(llpt_pkg::REQ_REPORT, 32'hFFFF_FFFF, 16'hFFFF, 7'd127));
		send_word(make_word(llpt_pkg::REQ_PICK, 32'd0, 16'd0, 7'd0));
		send_word(make_word(llpt_pkg::REQ_REPORT, 32'd0, 16'd0, 7'd101));
		send_word(make_word(llpt_pkg::REQ_PICK, 32'd0, 16'd0, 7'd0));
		// load limit boundary and a tie
		send_word(make_word(llpt_pkg::REQ_REPORT, 32'd1, 16'd1, 7'd100));
		send_word(make_word(llpt_pkg::REQ_PICK, '1, 16'd0, 7'd55));
		send_word(make_word(llpt_pkg::REQ_REPORT, 32'd2, 16'd2, 7'd100));
		send_word(make_word(llpt_pkg::REQ_PICK, 32'd0, '1, 7'd0));
		// updates and partial matches
		send_word(make_word(llpt_pkg::REQ_REPORT, 32'hFFFF_FFFF, 16'hFFFF, 7'd0));
		send_word(make_word(llpt_pkg::REQ_PICK, 32'd0, 16'd0, 7'd127));
		send_word(make_word(llpt_pkg::REQ_REPORT, 32'hFFFF_FFFF, 16'd0, 7'd50));
		send_word(make_word(llpt_pkg::REQ_REPORT, 32'd0, 16'hFFFF, 7'd3));
		send_word(make_word(llpt_pkg::REQ_PICK, 32'd0, 16'd0, 7'd0));
		send_word(make_word(llpt_pkg::REQ_REPORT, 32'd0, 16'd0, 7'd0));
		send_word(make_word(llpt_pkg::REQ_PICK, 32'd0, 16'd0, 7'd0));
		send_word(make_word(llpt_pkg::REQ_REPORT, 32'hFFFF_FFFF, 16'hFFFF, 7'd127));
		send_word(make_word(llpt_pkg::REQ_PICK, 32'd0, 16'd0, 7'd0));

		for (int k = 0; k < 1630; k++) begin
			if (k % 128 == 0)
				gap_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
			send_word(random_word());
		end
		req_valid <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (40) @(posedge clk);
		if (fails == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// response side back-pressure with one long hold-off
	initial begin
		int hold;
		int taken;
		int stall_max;
		taken = 0;
		stall_max = 5;
		forever begin
			if (taken % 64 == 0)
				stall_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
			if (taken == 300)
				hold = 400;
			else
				hold = $urandom_range(0, stall_max);
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!(rsp_valid && !rsp_stall));
			taken++;
		end
	end

	initial begin
		#600000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/llpt_pkg.sv
hdl/llpt_ram.sv
hdl/least_loaded_peer_table_core.sv
test/llpt_monitor.sv
test/tb_least_loaded_peer_table_core.sv
